### hdl/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, key codes and the key-code normalization function for the
// hotkey chord detector.
// ----------------------------------------------------------------------------
package hcd_pkg;

  // Full span of an 8-bit key code
  localparam int unsigned MAP_SPAN = 256;

  localparam logic [7:0] NO_KEY     = 8'hFF;
  localparam logic [7:0] K_NONE     = 8'h00;
  localparam logic [7:0] K_SHIFT    = 8'h10;
  localparam logic [7:0] K_CONTROL  = 8'h11;
  localparam logic [7:0] K_MENU     = 8'h12;
  localparam logic [7:0] K_LWIN     = 8'h5B;
  localparam logic [7:0] K_RWIN     = 8'h5C;
  localparam logic [7:0] K_LSHIFT   = 8'hA0;
  localparam logic [7:0] K_RSHIFT   = 8'hA1;
  localparam logic [7:0] K_LCONTROL = 8'hA2;
  localparam logic [7:0] K_RCONTROL = 8'hA3;
  localparam logic [7:0] K_LMENU    = 8'hA4;
  localparam logic [7:0] K_RMENU    = 8'hA5;

  localparam logic [7:0] SCAN_LSHIFT = 8'h2A;
  localparam logic [7:0] SCAN_RSHIFT = 8'h36;

  // Modifier bit positions
  localparam int unsigned MOD_CONTROL = 0;
  localparam int unsigned MOD_ALT     = 1;
  localparam int unsigned MOD_SHIFT   = 2;
  localparam int unsigned MOD_SUPER   = 3;

  // Configuration register indexes
  localparam logic REG_TARGET_KEY = 1'b0;
  localparam logic REG_REQ_MODS   = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified event passed from front to back
  typedef struct packed {
    logic [7:0] code;
    logic       rel;
    logic       ign;
  } evt_t;

  function automatic logic [7:0] normalize(input logic [7:0] vk,
                                           input logic [7:0] scan,
                                           input logic       ext);
    logic [7:0] code;
    code = vk;
    if (vk == NO_KEY) begin
      code = K_NONE;
    end else if (vk == K_SHIFT) begin
      if (scan == SCAN_LSHIFT) begin
        code = K_LSHIFT;
      end else if (scan == SCAN_RSHIFT) begin
        code = K_RSHIFT;
      end
    end else if (vk == K_CONTROL) begin
      code = ext ? K_RCONTROL : K_LCONTROL;
    end else if (vk == K_MENU) begin
      code = ext ? K_RMENU : K_LMENU;
    end
    return code;
  endfunction

endpackage

### hdl/hcd_front.sv
// ----------------------------------------------------------------------------
// hcd_front
// Input stage: accepts a key event word, normalizes the key code and marks
// events that leave the pressed map untouched.
// ----------------------------------------------------------------------------
module hcd_front #(
  parameter int unsigned KEY_CODES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       virtual_key,
  input  logic [7:0]       scan_code,
  input  logic             extended_prefix,
  input  logic             key_release,
  output logic             evt_valid,
  input  logic             evt_ready,
  output hcd_pkg::evt_t    evt
);

  logic          v_r, v_nxt;
  hcd_pkg::evt_t evt_r, evt_nxt;
  logic [7:0]    code;

  assign in_ready = !v_r || evt_ready;
  assign code     = hcd_pkg::normalize(virtual_key, scan_code, extended_prefix);

  always_comb begin
    v_nxt   = v_r;
    evt_nxt = evt_r;
    if (v_r && evt_ready) begin
      v_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      v_nxt        = 1'b1;
      evt_nxt.code = code;
      evt_nxt.rel  = key_release;
      // mark null keys and codes past the end of the map as ignored
      evt_nxt.ign  = (code == hcd_pkg::K_NONE) || ({1'b0, code} >= 9'(KEY_CODES));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    evt_r <= evt_nxt;
  end

  assign evt_valid = v_r;
  assign evt       = evt_r;

endmodule

### hdl/hcd_queue.sv
// ----------------------------------------------------------------------------
// hcd_queue
// Short FIFO between the front and back parts of the detector.
// ----------------------------------------------------------------------------
module hcd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  hcd_pkg::evt_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output hcd_pkg::evt_t rd_data
);

  localparam int unsigned PTR_W = $clog2(hcd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(hcd_pkg::QUEUE_DEPTH + 1);

  hcd_pkg::evt_t            slot_r [hcd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     push, pop;

  assign wr_ready = cnt_r != CNT_W'(hcd_pkg::QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(hcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(hcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/hcd_back.sv
// ----------------------------------------------------------------------------
// hcd_back
// Execution stage: updates the pressed map, reads the held modifiers and
// matches the chord; the result sits in an output register.
// ----------------------------------------------------------------------------
module hcd_back #(
  parameter int unsigned KEY_CODES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          evt_valid,
  output logic          evt_ready,
  input  hcd_pkg::evt_t evt,
  input  logic [7:0]    target_key,
  input  logic [3:0]    required_modifiers,
  output logic          res_valid,
  input  logic          res_ready,
  output logic          hotkey_hit,
  output logic          event_ignored
);

  localparam int unsigned IDX_W = $clog2(KEY_CODES);

  logic [KEY_CODES-1:0]         map_r, map_nxt;
  logic [hcd_pkg::MAP_SPAN-1:0] held;
  logic [IDX_W-1:0]             idx;
  logic                         take, was_down, hit;
  logic [3:0]                   mods;
  logic                         v_r, v_nxt;
  logic                         hit_r, hit_nxt;
  logic                         ign_r, ign_nxt;

  assign evt_ready = !v_r || res_ready;
  assign take      = evt_valid && evt_ready;
  assign idx       = evt.code[IDX_W-1:0];
  assign was_down  = map_r[idx];

  always_comb begin
    map_nxt = map_r;
    if (take && !evt.ign) begin
      map_nxt[idx] = !evt.rel;
    end
  end

  // modifiers read after this word's own map update
  assign held = hcd_pkg::MAP_SPAN'(map_nxt);
  always_comb begin
    mods = '0;
    mods[hcd_pkg::MOD_CONTROL] = held[hcd_pkg::K_CONTROL] || held[hcd_pkg::K_LCONTROL]
                                 || held[hcd_pkg::K_RCONTROL];
    mods[hcd_pkg::MOD_ALT]     = held[hcd_pkg::K_MENU] || held[hcd_pkg::K_LMENU]
                                 || held[hcd_pkg::K_RMENU];
    mods[hcd_pkg::MOD_SHIFT]   = held[hcd_pkg::K_SHIFT] || held[hcd_pkg::K_LSHIFT]
                                 || held[hcd_pkg::K_RSHIFT];
    mods[hcd_pkg::MOD_SUPER]   = held[hcd_pkg::K_LWIN] || held[hcd_pkg::K_RWIN];
  end

  // fresh press only: repeats and releases never fire
  assign hit = !evt.ign && !evt.rel && !was_down && (target_key != hcd_pkg::K_NONE)
               && (evt.code == target_key) && (mods == required_modifiers);

  always_comb begin
    v_nxt   = v_r;
    hit_nxt = hit_r;
    ign_nxt = ign_r;
    if (v_r && res_ready) begin
      v_nxt = 1'b0;
    end
    if (take) begin
      v_nxt   = 1'b1;
      hit_nxt = hit;
      ign_nxt = evt.ign;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      map_r <= '0;
    end else begin
      v_r   <= v_nxt;
      map_r <= map_nxt;
    end
    hit_r <= hit_nxt;
    ign_r <= ign_nxt;
  end

  assign res_valid     = v_r;
  assign hotkey_hit    = hit_r;
  assign event_ignored = ign_r;

endmodule

### hdl/hotkey_chord_detector_top.sv
// ----------------------------------------------------------------------------
// hotkey_chord_detector_top
// Keyboard event stream in, one match result word out per event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one key event word per handshake (key code, scan
//   code, E0 prefix, release flag). Output channel out_*: one result word
//   per event, in order, with the hit flag and the ignored flag.
//   Configuration: write target_key (index 0) and required_modifiers
//   (index 1) through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Timing:
//   out_tvalid rises once the accepted word has been loaded into the front
//   register, the two-entry event queue and the back output register, in
//   that order.
//   Throughput is one event per cycle while out_tready stays high, set by the
//   map update and chord compare in the back stage.
// Reset:
//   rst_n clears the pressed map (no key down), the queue, both valid
//   flags and the configuration registers; no sweep is needed.
// Stalls:
//   When out_tready is low the result holds in the output register; the
//   queue keeps absorbing events until it and the front register fill,
//   then in_tready drops.
// ----------------------------------------------------------------------------
module hotkey_chord_detector_top #(
  parameter int unsigned KEY_CODES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] virtual_key, [15:8] scan_code, [16] extended_prefix,
  // [17] key_release, [23:18] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] hotkey_hit, [1] event_ignored, [7:2] zero
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]    target_r;
  logic [3:0]    req_mods_r;
  logic          f_valid, f_ready;
  hcd_pkg::evt_t f_evt;
  logic          q_valid, q_ready;
  hcd_pkg::evt_t q_evt;
  logic          hotkey_hit, event_ignored;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      req_mods_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hcd_pkg::REG_TARGET_KEY: target_r   <= cfg_wdata;
        hcd_pkg::REG_REQ_MODS:   req_mods_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  hcd_front #(.KEY_CODES(KEY_CODES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .virtual_key     (in_tdata[7:0]),
    .scan_code       (in_tdata[15:8]),
    .extended_prefix (in_tdata[16]),
    .key_release     (in_tdata[17]),
    .evt_valid       (f_valid),
    .evt_ready       (f_ready),
    .evt             (f_evt)
  );

  hcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_evt),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_evt)
  );

  hcd_back #(.KEY_CODES(KEY_CODES)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt_valid          (q_valid),
    .evt_ready          (q_ready),
    .evt                (q_evt),
    .target_key         (target_r),
    .required_modifiers (req_mods_r),
    .res_valid          (out_tvalid),
    .res_ready          (out_tready),
    .hotkey_hit         (hotkey_hit),
    .event_ignored      (event_ignored)
  );

  assign out_tdata = {6'b0, event_ignored, hotkey_hit};

endmodule

### hdl/hcd_checker.sv
// ----------------------------------------------------------------------------
// hcd_checker
// Port-level checks for the hotkey chord detector, bound to the top level.
// ----------------------------------------------------------------------------
module hcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // no result word comes out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // an ignored event never fires
  a_hit_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit on an ignored event");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b0)
    else $error("result padding not zero");

endmodule

bind hotkey_chord_detector_top hcd_checker u_hcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
